>>> sv/stq_pkg.sv
package stq_pkg;

  localparam int DefaultDepth = 16;
  localparam int MaxResults   = 16;
  localparam int FifoDepth    = 2;

  localparam int TimeW = 48;
  localparam int IvalW = 31;
  localparam int IdW   = 16;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_e;

  // One classified command: expiry for an add, current time for a tick.
  typedef struct packed {
    op_e              op;
    logic [TimeW-1:0] stamp;
    logic [IdW-1:0]   id;
  } cmd_t;

endpackage

>>> sv/sorted_timer_queue.sv
// Sorted timer queue: holds up to DEPTH pending timers ordered by expiry.
// Input channel (in_valid_i / in_ready_o) carries one item per operation:
//   op_i = 0 adds a timer; expiry = start_time_i + interval_ms_i, saturated
//   at the top of the 48-bit range; ties keep insertion order.
//   op_i = 1 is a tick carrying now_time_i.
// Output channel (out_valid_o / out_ready_i) carries results:
//   add  -> one item, kind_o accepted or rejected-full, last_o = 1.
//   tick -> one kind_o expired item per due timer, earliest first, up to
//           16 per tick, last_o on the final one; nothing if none is due.
// Results come from the back end's output register. A tick's expiries follow
// one per cycle while the receiver is ready. A tick with nothing due still
// passes through the tick state of the back end. An add is handled in the idle
// state; all cells compare against the new expiry at once.
// A 2-entry command queue between the front (expiry add) and the back (cell
// chain) keeps input accepting while the back end works.
// Reset empties the queue; cell contents are left undefined and never read.
// When the receiver stalls the output register holds and the chain freezes;
// input stalls once the command queue fills.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int DEPTH = DefaultDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [TimeW-1:0] start_time_i,
  input  logic [IvalW-1:0] interval_ms_i,
  input  logic [IdW-1:0]   timer_id_i,
  input  logic [TimeW-1:0] now_time_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       kind_o,
  output logic [IdW-1:0]   expired_id_o,
  output logic             last_o
);

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  stq_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .start_time_i  (start_time_i),
    .interval_ms_i (interval_ms_i),
    .timer_id_i    (timer_id_i),
    .now_time_i    (now_time_i),
    .cmd_valid_o   (front_valid),
    .cmd_ready_i   (front_ready),
    .cmd_o         (front_cmd)
  );

  // Command queue parting front and back.
  stq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  stq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (back_valid),
    .cmd_ready_o  (back_ready),
    .cmd_i        (back_cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .expired_id_o (expired_id_o),
    .last_o       (last_o)
  );

endmodule

>>> sv/stq_front.sv
module stq_front
  import stq_pkg::*;
(
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [TimeW-1:0] start_time_i,
  input  logic [IvalW-1:0] interval_ms_i,
  input  logic [IdW-1:0]   timer_id_i,
  input  logic [TimeW-1:0] now_time_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cmd_t             cmd_o
);

  logic [TimeW:0]   sum;
  logic [TimeW-1:0] expiry;

  // Saturating expiry, top of the time range on carry out.
  assign sum    = {1'b0, start_time_i} + (TimeW + 1)'(interval_ms_i);
  assign expiry = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];

  always_comb begin
    cmd_o.op    = op_e'(op_i);
    cmd_o.stamp = (op_e'(op_i) == OP_TICK) ? now_time_i : expiry;
    cmd_o.id    = timer_id_i;
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

>>> sv/stq_fifo.sv
module stq_fifo
  import stq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);

  cmd_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(FifoDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push && !pop)      cnt_q <= cnt_q + CntW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

>>> sv/stq_back.sv
module stq_back
  import stq_pkg::*;
#(
  parameter int DEPTH = DefaultDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  cmd_t           cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [IdW-1:0] expired_id_o,
  output logic           last_o
);

  localparam int CntW    = $clog2(DEPTH + 1);
  localparam int PopW    = $clog2(MaxResults);
  localparam int NextIdx = (DEPTH > 1) ? 1 : 0;

  typedef enum logic {
    ST_IDLE,
    ST_TICK
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  count_q;
  logic [PopW-1:0]  popped_q;
  logic [TimeW-1:0] now_q;
  logic             out_valid_q, last_q;
  kind_e            kind_q;
  logic [IdW-1:0]   id_out_q;

  // Sorted cell chain, earliest at cell 0.
  logic [TimeW-1:0] exp_q [DEPTH];
  logic [IdW-1:0]   id_q  [DEPTH];
  logic [DEPTH-1:0] le;

  logic can_load, full, head_due, next_due;
  logic do_add, do_insert, take_tick, do_pop, last_pop;

  for (genvar g = 0; g < DEPTH; g++) begin : g_le
    assign le[g] = (CntW'(g) < count_q) && (exp_q[g] <= cmd_i.stamp);
  end

  assign can_load  = !out_valid_q || out_ready_i;
  assign full      = (count_q == CntW'(DEPTH));
  assign head_due  = (count_q != '0) && (exp_q[0] <= now_q);
  assign next_due  = (count_q > CntW'(1)) && (exp_q[NextIdx] <= now_q);

  assign do_add    = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_ADD) && can_load;
  assign do_insert = do_add && !full;
  assign take_tick = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_TICK);
  assign do_pop    = (state_q == ST_TICK) && can_load && head_due;
  assign last_pop  = !next_due || (popped_q == PopW'(MaxResults - 1));

  assign cmd_ready_o = do_add || take_tick;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic             prev_le;
    logic [TimeW-1:0] prev_exp, next_exp;
    logic [IdW-1:0]   prev_id, next_id;

    if (g == 0) begin : g_head
      assign prev_le  = 1'b1;
      assign prev_exp = exp_q[g];
      assign prev_id  = id_q[g];
    end else begin : g_mid
      assign prev_le  = le[g-1];
      assign prev_exp = exp_q[g-1];
      assign prev_id  = id_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_exp = exp_q[g];
      assign next_id  = id_q[g];
    end else begin : g_body
      assign next_exp = exp_q[g+1];
      assign next_id  = id_q[g+1];
    end

    // On insert, cells before the insert point hold; the insert cell takes the
    // new entry; later cells shift down by one. A pop shifts every cell up by one.
    always_ff @(posedge clk_i) begin
      if (do_insert && !le[g]) begin
        exp_q[g] <= prev_le ? cmd_i.stamp : prev_exp;
        id_q[g]  <= prev_le ? cmd_i.id : prev_id;
      end else if (do_pop) begin
        exp_q[g] <= next_exp;
        id_q[g]  <= next_id;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      popped_q    <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_ACCEPT;
      id_out_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      // Output register loads an add answer or an expiry, else drains.
      if (can_load) out_valid_q <= do_add || do_pop;
      unique case (state_q)
        ST_IDLE: begin
          if (do_add) begin
            kind_q      <= full ? KIND_FULL : KIND_ACCEPT;
            id_out_q    <= '0;
            last_q      <= 1'b1;
            if (!full) count_q <= count_q + CntW'(1);
          end else if (take_tick) begin
            now_q    <= cmd_i.stamp;
            popped_q <= '0;
            state_q  <= ST_TICK;
          end
        end
        ST_TICK: begin
          if (can_load) begin
            if (head_due) begin
              kind_q      <= KIND_EXPIRED;
              id_out_q    <= id_q[0];
              last_q      <= last_pop;
              count_q     <= count_q - CntW'(1);
              popped_q    <= popped_q + PopW'(1);
              if (last_pop) state_q <= ST_IDLE;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign expired_id_o = id_out_q;
  assign last_o       = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |-> (count_q != '0))
    else $error("pop from empty chain");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow count");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(count_q))
    else $error("chain changed while output stalled");

  a_full_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !do_insert)
    else $error("insert into full chain");

endmodule

>>> tb/sorted_timer_queue_test.sv
`timescale 1ns / 100ps

module sorted_timer_queue_test;
  import stq_pkg::*;

  localparam logic [TimeW-1:0] TimeMax    = {TimeW{1'b1}};
  localparam logic [IvalW-1:0] IvalMax    = {IvalW{1'b1}};
  localparam int               QueueDepth = DefaultDepth;
  localparam int               RandItems  = 92;
  localparam int               CycleLimit = 200000;
  localparam int               ReportMax  = 10;

  // One input item plus an optional hand-written expectation.
  // When typed is set, n_typed results (0 or 1) of t_kind / t_id are
  // expected instead of what the shadow queue computes.
  typedef struct {
    op_e              op;
    logic [TimeW-1:0] start;
    logic [IvalW-1:0] ival;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] now;
    bit               typed;
    int               n_typed;
    kind_e            t_kind;
    logic [IdW-1:0]   t_id;
  } stim_t;

  typedef struct {
    kind_e          kind;
    logic [IdW-1:0] id;
    logic           last;
  } result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             op_i = OP_ADD;
  logic [TimeW-1:0] start_time_i = '0;
  logic [IvalW-1:0] interval_ms_i = '0;
  logic [IdW-1:0]   timer_id_i = '0;
  logic [TimeW-1:0] now_time_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [1:0]       kind_o;
  logic [IdW-1:0]   expired_id_o;
  logic             last_o;

  // Shadow copy of the timer queue, sorted by expiry, earliest first.
  logic [TimeW-1:0] shadow_expiry [QueueDepth];
  logic [IdW-1:0]   shadow_id     [QueueDepth];
  int               shadow_count;

  result_t pending_results[$];
  stim_t   plan[$];

  int  err_cnt;
  int  cycle_cnt = 0;
  int  n_add, n_full, n_tick, n_rx, n_rx_expired;
  // While calm is set neither side idles.
  bit  calm;

  sorted_timer_queue DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .start_time_i (start_time_i),
    .interval_ms_i(interval_ms_i),
    .timer_id_i   (timer_id_i),
    .now_time_i   (now_time_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .expired_id_o (expired_id_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic logic [TimeW-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TimeW-1:0];
  endfunction

  function automatic stim_t make_row(op_e op, logic [TimeW-1:0] start,
                                     logic [IvalW-1:0] ival, logic [IdW-1:0] id,
                                     logic [TimeW-1:0] now, bit typed = 1'b0,
                                     int n_typed = 0, kind_e t_kind = KIND_ACCEPT,
                                     logic [IdW-1:0] t_id = '0);
    stim_t s;
    s.op      = op;
    s.start   = start;
    s.ival    = ival;
    s.id      = id;
    s.now     = now;
    s.typed   = typed;
    s.n_typed = n_typed;
    s.t_kind  = t_kind;
    s.t_id    = t_id;
    return s;
  endfunction

  // Applies one accepted item to the shadow queue and queues the results
  // it should cause.
  task automatic apply_to_shadow_queue(input stim_t s);
    logic [TimeW:0]   sum;
    logic [TimeW-1:0] expiry;
    int               pos;
    int               due;
    result_t          r;
    result_t          computed[$];
    if (s.op == OP_ADD) begin
      n_add++;
      sum    = {1'b0, s.start} + (TimeW + 1)'(s.ival);
      // Expiry saturates at the top of the time range.
      expiry = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
      r.id   = '0;
      r.last = 1'b1;
      if (shadow_count >= QueueDepth) begin
        n_full++;
        r.kind = KIND_FULL;
      end else begin
        // Insert after every entry with expiry <= new one: ties stay FIFO.
        pos = 0;
        while (pos < shadow_count && shadow_expiry[pos] <= expiry) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_expiry[i] = shadow_expiry[i-1];
          shadow_id[i]     = shadow_id[i-1];
        end
        shadow_expiry[pos] = expiry;
        shadow_id[pos]     = s.id;
        shadow_count++;
        r.kind = KIND_ACCEPT;
      end
      computed.push_back(r);
    end else begin
      n_tick++;
      due = 0;
      while (due < shadow_count && due < MaxResults && shadow_expiry[due] <= s.now) due++;
      for (int i = 0; i < due; i++) begin
        r.kind = KIND_EXPIRED;
        r.id   = shadow_id[i];
        r.last = (i + 1 == due);
        computed.push_back(r);
      end
      for (int i = due; i < shadow_count; i++) begin
        shadow_expiry[i-due] = shadow_expiry[i];
        shadow_id[i-due]     = shadow_id[i];
      end
      shadow_count -= due;
    end
    if (s.typed) begin
      for (int i = 0; i < s.n_typed; i++) begin
        r.kind = s.t_kind;
        r.id   = s.t_id;
        r.last = (i + 1 == s.n_typed);
        pending_results.push_back(r);
      end
    end else begin
      foreach (computed[i]) pending_results.push_back(computed[i]);
    end
  endtask

  // Presents one item and holds it until accepted. Called at a rising edge;
  // each path makes at most one assignment to in_valid_i per edge.
  task automatic send_item(input stim_t s);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= s.op;
    start_time_i  <= s.start;
    interval_ms_i <= s.ival;
    timer_id_i    <= s.id;
    now_time_i    <= s.now;
    do @(posedge clk_i); while (!in_ready_o);
    apply_to_shadow_queue(s);
  endtask

  function automatic void flag_mismatch(string what, logic [IdW-1:0] exp_v,
                                        logic [IdW-1:0] act_v);
    err_cnt++;
    if (err_cnt <= ReportMax) begin
      $display("[%0d] mismatch on %s: expected %0h, got %0h", cycle_cnt, what, exp_v, act_v);
    end
  endfunction

  // Result side: compare each accepted result against the oldest
  // expectation, then roll ready for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_rx++;
        if (kind_o == KIND_EXPIRED) n_rx_expired++;
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= ReportMax) begin
            $display("[%0d] unexpected result: kind %0d id %0h last %0b",
                     cycle_cnt, kind_o, expired_id_o, last_o);
          end
        end else begin
          r = pending_results.pop_front();
          if (kind_o !== r.kind) flag_mismatch("kind", IdW'(r.kind), IdW'(kind_o));
          if (expired_id_o !== r.id) flag_mismatch("expired_id", r.id, expired_id_o);
          if (last_o !== r.last) flag_mismatch("last", IdW'(r.last), IdW'(last_o));
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 25);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [TimeW-1:0] clock_ms;
    stim_t            s;
    int               roll;
    int               flavor;

    err_cnt      = 0;
    shadow_count = 0;
    n_add        = 0;
    n_full       = 0;
    n_tick       = 0;
    n_rx         = 0;
    n_rx_expired = 0;
    calm         = 1'b0;

    // Directed plan.
    // Ticks on an empty queue, at both ends of the time range: no result.
    plan.push_back(make_row(OP_TICK, '0, '0, '0, '0, 1, 0));
    plan.push_back(make_row(OP_TICK, TimeMax, IvalMax, '1, TimeMax, 1, 0));
    // Smallest add, then two adds whose expiry saturates (equal, so FIFO).
    plan.push_back(make_row(OP_ADD, '0, '0, '0, TimeMax, 1, 1, KIND_ACCEPT));
    plan.push_back(make_row(OP_ADD, TimeMax, IvalMax, 16'hFFFF, '0, 1, 1, KIND_ACCEPT));
    plan.push_back(make_row(OP_ADD, TimeMax - 48'd100, 31'd200, 16'h1234, '0,
                            1, 1, KIND_ACCEPT));
    // Only the zero-expiry timer is due at time zero.
    plan.push_back(make_row(OP_TICK, '1, '1, '1, '0, 1, 1, KIND_EXPIRED, 16'h0000));
    // One short of saturation: nothing due.
    plan.push_back(make_row(OP_TICK, '0, '0, '0, TimeMax - 48'd1, 1, 0));
    // At the very top both saturated timers go, in insertion order.
    plan.push_back(make_row(OP_TICK, '0, '0, '0, TimeMax));
    // Fill the queue with many equal expiries, then one add too many.
    for (int i = 0; i < QueueDepth; i++) begin
      plan.push_back(make_row(OP_ADD, 48'(((i * 7) % 5) * 100), '0, 16'hA000 + 16'(i),
                              TimeMax));
    end
    plan.push_back(make_row(OP_ADD, '0, '0, 16'hBEEF, '0, 1, 1, KIND_FULL));
    // Partial drain, then everything that is left.
    plan.push_back(make_row(OP_TICK, '1, '1, '1, 48'd250));
    plan.push_back(make_row(OP_TICK, '0, '0, '0, TimeMax));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_item(plan[i]);

    // Random part: a running clock with timers set a little ahead of it,
    // plus some full-range and near-top values. Adds outweigh ticks so the
    // queue fills up and rejects now and then.
    clock_ms = rand_time() >> 8;
    for (int n = 0; n < RandItems; n++) begin
      calm    = (n >= 50 && n < 80);
      roll    = $urandom_range(99);
      flavor  = $urandom_range(9);
      s       = make_row(OP_ADD, rand_time(), IvalW'($urandom()), IdW'($urandom()),
                         rand_time());
      if (roll < 55) begin
        if (flavor == 1) begin
          s.start = TimeMax - TimeW'($urandom_range(5000));
        end else if (flavor > 1) begin
          s.start = clock_ms - TimeW'($urandom_range(200));
          // Coarse steps so equal expiries show up.
          s.ival  = IvalW'($urandom_range(30) * 100);
        end
      end else begin
        s.op = OP_TICK;
        if (flavor == 0) begin
          s.now = '0;
        end else if (flavor == 1) begin
          s.now = TimeMax;
        end else if (flavor > 2) begin
          clock_ms = clock_ms + TimeW'($urandom_range(1500));
          s.now    = clock_ms;
        end
      end
      send_item(s);
    end
    calm = 1'b0;
    // Flush whatever is still pending.
    send_item(make_row(OP_TICK, '0, '0, '0, TimeMax));
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    // A tick with nothing due may still be in flight.
    repeat (20) @(posedge clk_i);

    $display("Sent %0d adds (%0d to a full queue) and %0d ticks.", n_add, n_full, n_tick);
    $display("Checked %0d results, %0d of them expiries; %0d mismatches.",
             n_rx, n_rx_expired, err_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
